// ===== rtl/ic3_pkg.sv =====
// shared types and constants for the 3x3 image convolution block
// no dependencies
package ic3_pkg;

    localparam int unsigned PIX_W   = 8;
    localparam int unsigned PIX_MAX = 255;
    localparam int unsigned KSIZE   = 3;
    localparam int unsigned ROW_W   = 10;
    localparam int unsigned PLANE_W = 2;
    localparam int unsigned CFG_W   = 24;
    localparam int unsigned DIM_W   = 11;
    localparam int unsigned ROW_LIMIT = 1024;

    // configuration register indexes
    localparam logic [2:0] REG_COEF_TOP = 3'd0;
    localparam logic [2:0] REG_COEF_MID = 3'd1;
    localparam logic [2:0] REG_COEF_BOT = 3'd2;
    localparam logic [2:0] REG_DIVISOR  = 3'd3;
    localparam logic [2:0] REG_WIDTH    = 3'd4;
    localparam logic [2:0] REG_HEIGHT   = 3'd5;

    // result position tag carried with each window
    typedef struct packed {
        logic [PLANE_W-1:0] plane;
        logic [ROW_W-1:0]   row;
        logic [ROW_W-1:0]   col;
        logic               eoi;
    } ic3_tag_t;

endpackage

// ===== rtl/ic3_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module ic3_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ic3_front.sv =====
// front end: raster counters, line stores and the 3x3 window; emits interior windows
// depends on ic3_pkg and ic3_ram
module ic3_front #(
    parameter int unsigned MAX_WIDTH = 1024,
    parameter int unsigned PLANES    = 3
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ic3_pkg::PIX_W-1:0]       pixel,
    input  logic [ic3_pkg::DIM_W-1:0]       width_cfg,
    input  logic [ic3_pkg::DIM_W-1:0]       height_cfg,
    output logic                            win_valid,
    input  logic                            win_ready,
    output logic [9*ic3_pkg::PIX_W-1:0]     win_data,
    output ic3_pkg::ic3_tag_t               win_tag
);

    localparam int unsigned AW  = $clog2(MAX_WIDTH);
    localparam int unsigned CW  = $clog2(MAX_WIDTH + 1);
    localparam int unsigned PW  = ic3_pkg::PIX_W;
    localparam int unsigned RW  = ic3_pkg::ROW_W;
    localparam logic [ic3_pkg::DIM_W-1:0] DIM_KS = ic3_pkg::DIM_W'(ic3_pkg::KSIZE);

    // stage 1: pixel accepted, line store read issued
    logic           s1_valid_reg;
    logic [PW-1:0]  s1_pix_reg;
    logic [AW-1:0]  s1_idx_reg;
    logic           s1_emit_reg;
    ic3_pkg::ic3_tag_t s1_tag_reg;

    logic [CW-1:0]  col_reg, col_next;
    logic [RW:0]    row_reg, row_next;
    logic [ic3_pkg::PLANE_W-1:0] plane_reg, plane_next;

    logic [CW-1:0]  w_eff;
    logic [RW:0]    h_eff;
    logic [AW-1:0]  idx;
    logic           last_col, last_row, last_plane;
    logic           accept;
    logic [PW-1:0]  old_rd, new_rd;
    logic [PW-1:0]  win_reg [9];
    logic           out_valid_reg;
    ic3_pkg::ic3_tag_t out_tag_reg;
    logic           adv;

    // effective dimensions
    always_comb
    begin
        if (width_cfg < DIM_KS)
            w_eff = CW'(ic3_pkg::KSIZE);
        else if (width_cfg > ic3_pkg::DIM_W'(MAX_WIDTH))
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(width_cfg);
        if (height_cfg < DIM_KS)
            h_eff = (RW+1)'(ic3_pkg::KSIZE);
        else if (height_cfg > ic3_pkg::DIM_W'(ic3_pkg::ROW_LIMIT))
            h_eff = (RW+1)'(ic3_pkg::ROW_LIMIT);
        else
            h_eff = (RW+1)'(height_cfg);
    end

    // stage 1 can advance when the window register is free or drains
    assign adv      = !out_valid_reg || win_ready;
    assign in_ready = adv;
    assign accept   = in_valid && in_ready;

    assign idx        = (col_reg < CW'(MAX_WIDTH)) ? col_reg[AW-1:0] : AW'(MAX_WIDTH - 1);
    assign last_col   = (CW+1)'(col_reg) + 1'b1 >= (CW+1)'(w_eff);
    assign last_row   = (RW+2)'(row_reg) + 1'b1 >= (RW+2)'(h_eff);
    assign last_plane = 3'(plane_reg) + 3'd1 >= 3'(PLANES);

    // raster counters
    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        plane_next = plane_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                if (last_row)
                begin
                    row_next   = '0;
                    plane_next = last_plane ? '0 : plane_reg + 1'b1;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            plane_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            plane_reg <= plane_next;
            if (adv)
                s1_valid_reg <= accept;
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= pixel;
            s1_idx_reg  <= idx;
            s1_emit_reg <= (row_reg >= (RW+1)'(2)) && (col_reg >= CW'(2));
            s1_tag_reg.plane <= plane_reg;
            s1_tag_reg.row   <= RW'(row_reg - 1'b1);
            s1_tag_reg.col   <= RW'(col_reg - 1'b1);
            s1_tag_reg.eoi   <= last_plane && last_row && last_col;
        end
    end

    // line stores: read at accept, written when stage 1 retires
    ic3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_older (
        .clk(clk), .we(s1_valid_reg && adv), .waddr(s1_idx_reg), .wdata(new_rd),
        .re(accept), .raddr(idx), .rdata(old_rd)
    );
    ic3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_newer (
        .clk(clk), .we(s1_valid_reg && adv), .waddr(s1_idx_reg), .wdata(s1_pix_reg),
        .re(accept), .raddr(idx), .rdata(new_rd)
    );

    // window shift and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else if (adv)
        begin
            out_valid_reg <= s1_valid_reg && s1_emit_reg;
            if (s1_valid_reg)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r*3]   <= win_reg[r*3+1];
                    win_reg[r*3+1] <= win_reg[r*3+2];
                end
                win_reg[2] <= old_rd;
                win_reg[5] <= new_rd;
                win_reg[8] <= s1_pix_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
            out_tag_reg <= s1_tag_reg;
    end

    assign win_valid = out_valid_reg;
    assign win_tag   = out_tag_reg;
    always_comb
    begin
        for (int i = 0; i < 9; i++)
            win_data[i*PW +: PW] = win_reg[i];
    end

    // a same-address read-during-write cannot occur: consecutive pixels differ in column
    a_idx_differs: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && adv && accept && MAX_WIDTH > 1) |-> (idx != s1_idx_reg) || (w_eff == CW'(1)))
        else $error("line store read collides with write");
    a_counter_range: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (col_reg < w_eff) || $past(!last_col))
        else $error("column counter past width");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (win_valid && !win_ready) |=> win_valid && $stable(win_tag))
        else $error("stalled window changed");

endmodule

// ===== rtl/ic3_queue.sv =====
// short queue between the window front end and the arithmetic back end
// no dependencies
module ic3_queue #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    output logic             empty,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wptr_reg, rptr_reg;
    logic [1:0]       count_reg;
    logic             do_push, do_pop;

    assign full    = count_reg == 2'd2;
    assign empty   = count_reg == 2'd0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= !wptr_reg;
            if (do_pop)
                rptr_reg <= !rptr_reg;
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wptr_reg] <= wdata;
    end

    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2) else $error("queue count overflow");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count wrong");
    a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> wptr_reg == rptr_reg)
        else $error("queue pointers disagree");

endmodule

// ===== rtl/ic3_back.sv =====
// back end: weighted sum, signed division by a serial divider, clamp and result register
// depends on ic3_pkg
module ic3_back #(
    parameter int unsigned COEF_BITS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_empty,
    output logic                         in_pop,
    input  logic [9*ic3_pkg::PIX_W-1:0]  win_data,
    input  ic3_pkg::ic3_tag_t            win_tag,
    input  logic [ic3_pkg::CFG_W-1:0]    coef_top,
    input  logic [ic3_pkg::CFG_W-1:0]    coef_mid,
    input  logic [ic3_pkg::CFG_W-1:0]    coef_bot,
    input  logic [ic3_pkg::DIM_W-1:0]    divisor_cfg,
    output logic                         empty,
    input  logic                         pop,
    output logic [ic3_pkg::PIX_W-1:0]    out_value,
    output ic3_pkg::ic3_tag_t            out_tag
);

    localparam int unsigned PW   = ic3_pkg::PIX_W;
    localparam int unsigned PRW  = PW + COEF_BITS + 1;
    localparam int unsigned SW   = PRW + 4;
    localparam int unsigned MW   = SW - 1;
    localparam int unsigned DW   = ic3_pkg::DIM_W;
    localparam int unsigned STW  = $clog2(MW + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } st_t;

    st_t state_reg, state_next;

    logic signed [PRW-1:0] prod_reg [9];
    logic signed [SW-1:0]  sum;
    logic [MW-1:0]         quo_reg;
    logic [DW:0]           rem_reg;
    logic [DW-1:0]         div_reg;
    logic                  neg_reg;
    logic [STW-1:0]        step_reg;
    logic [DW+1:0]         trial;
    logic [PW-1:0]         res_reg;
    logic                  res_valid_reg;
    ic3_pkg::ic3_tag_t     tag_reg, res_tag_reg;
    logic [ic3_pkg::CFG_W-1:0] regs [3];

    assign regs[0] = coef_top;
    assign regs[1] = coef_mid;
    assign regs[2] = coef_bot;

    // coefficient extract with bits beyond the register as zero
    function automatic logic signed [COEF_BITS:0] coef_at(input logic [ic3_pkg::CFG_W-1:0] r,
                                                          input int k);
        logic [ic3_pkg::CFG_W+3*COEF_BITS-1:0] ext;
        logic [COEF_BITS-1:0] raw;
        begin
            ext = {{(3*COEF_BITS){1'b0}}, r};
            raw = ext[k*COEF_BITS +: COEF_BITS];
            coef_at = {raw[COEF_BITS-1], raw};
        end
    endfunction

    // adder tree over the registered products
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < 9; i++)
            sum = sum + SW'(prod_reg[i]);
    end

    assign in_pop = (state_reg == ST_IDLE) && !in_empty;
    assign trial  = {rem_reg, quo_reg[MW-1]} - {2'b00, div_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (!in_empty) state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  if (step_reg == STW'(MW - 1)) state_next = ST_DONE;
            ST_DONE: if (!res_valid_reg || pop) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && (!res_valid_reg || pop))
                res_valid_reg <= 1'b1;
            else if (pop)
                res_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!in_empty)
                begin
                    tag_reg <= win_tag;
                    for (int r = 0; r < 3; r++)
                        for (int c = 0; c < 3; c++)
                            prod_reg[r*3+c] <= PRW'($signed({1'b0, win_data[(r*3+c)*PW +: PW]})
                                                    * coef_at(regs[r], c));
                end
            end
            ST_MUL:
            begin
                neg_reg  <= sum[SW-1];
                quo_reg  <= sum[SW-1] ? MW'(-sum) : MW'(sum);
                rem_reg  <= '0;
                div_reg  <= (divisor_cfg == '0) ? DW'(1) : divisor_cfg;
                step_reg <= '0;
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit a cycle
                if (!trial[DW+1])
                begin
                    rem_reg <= trial[DW:0];
                    quo_reg <= {quo_reg[MW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[DW-1:0], quo_reg[MW-1]};
                    quo_reg <= {quo_reg[MW-2:0], 1'b0};
                end
                step_reg <= step_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (!res_valid_reg || pop)
                begin
                    res_tag_reg <= tag_reg;
                    if (neg_reg && quo_reg != '0)
                        res_reg <= '0;
                    else if (quo_reg > MW'(ic3_pkg::PIX_MAX))
                        res_reg <= PW'(ic3_pkg::PIX_MAX);
                    else
                        res_reg <= quo_reg[PW-1:0];
                end
            end
            default: ;
        endcase
    end

    assign empty     = !res_valid_reg;
    assign out_value = res_reg;
    assign out_tag   = res_tag_reg;

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_pop |-> state_reg == ST_IDLE) else $error("pop outside idle");
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |=> state_reg == ST_DIV) else $error("divider not started");
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");

endmodule

// ===== rtl/image_convolution_3x3_clamp.sv =====
// 3x3 convolution with divide and clamp over a raster pixel stream
// an accepted interior pixel passes stage 1 and the window output register, then the queue,
// then the back end's idle, multiply, 20 divider steps and done states to its result
// border pixels one per cycle while the queue has room; the back end works on one interior
// result at a time, which backpressures the pixel input on a steady interior stream
// reset: asynchronous active low; counters, window, valid flags, states and configuration return to reset values
// depends on ic3_pkg, ic3_front, ic3_queue, ic3_back
module image_convolution_3x3_clamp #(
    parameter int unsigned MAX_WIDTH = 1024,
    parameter int unsigned COEF_BITS = 8,
    parameter int unsigned PLANES    = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  pixel,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_value,
    output logic [1:0]  out_plane,
    output logic [9:0]  out_row,
    output logic [9:0]  out_col,
    output logic        end_of_image,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int unsigned QW = 9 * ic3_pkg::PIX_W + $bits(ic3_pkg::ic3_tag_t);

    logic [23:0] coef_top_reg, coef_mid_reg, coef_bot_reg;
    logic [10:0] divisor_reg, width_reg, height_reg;
    logic        in_ready;
    logic        w_valid, w_ready, q_full, q_empty, q_pop;
    logic [9*ic3_pkg::PIX_W-1:0] w_data, q_data;
    ic3_pkg::ic3_tag_t w_tag, q_tag, r_tag;
    logic [QW-1:0] q_rd;

    assign cfg_ready = 1'b1;
    assign full      = !in_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_top_reg <= 24'd0;
            coef_mid_reg <= 24'd256;
            coef_bot_reg <= 24'd0;
            divisor_reg  <= 11'd1;
            width_reg    <= 11'd1024;
            height_reg   <= 11'd1024;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ic3_pkg::REG_COEF_TOP: coef_top_reg <= cfg_data;
                ic3_pkg::REG_COEF_MID: coef_mid_reg <= cfg_data;
                ic3_pkg::REG_COEF_BOT: coef_bot_reg <= cfg_data;
                ic3_pkg::REG_DIVISOR:  divisor_reg  <= cfg_data[10:0];
                ic3_pkg::REG_WIDTH:    width_reg    <= cfg_data[10:0];
                ic3_pkg::REG_HEIGHT:   height_reg   <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    ic3_front #(.MAX_WIDTH(MAX_WIDTH), .PLANES(PLANES)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(push), .in_ready(in_ready), .pixel(pixel),
        .width_cfg(width_reg), .height_cfg(height_reg),
        .win_valid(w_valid), .win_ready(w_ready), .win_data(w_data), .win_tag(w_tag)
    );

    assign w_ready = !q_full;

    ic3_queue #(.WIDTH(QW)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(w_valid), .full(q_full), .wdata({w_data, w_tag}),
        .empty(q_empty), .pop(q_pop), .rdata(q_rd)
    );

    assign q_data = q_rd[QW-1 -: 9*ic3_pkg::PIX_W];
    assign q_tag  = q_rd[$bits(ic3_pkg::ic3_tag_t)-1:0];

    ic3_back #(.COEF_BITS(COEF_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .in_empty(q_empty), .in_pop(q_pop),
        .win_data(q_data), .win_tag(q_tag),
        .coef_top(coef_top_reg), .coef_mid(coef_mid_reg), .coef_bot(coef_bot_reg),
        .divisor_cfg(divisor_reg),
        .empty(empty), .pop(pop), .out_value(out_value), .out_tag(r_tag)
    );

    assign out_plane    = r_tag.plane;
    assign out_row      = r_tag.row;
    assign out_col      = r_tag.col;
    assign end_of_image = r_tag.eoi;

endmodule
